// ===== src/sogifll_pkg.sv =====
// Shared types, register codes and constants of the SOGI-FLL quadrature generator.
`default_nettype none

package sogifll_pkg;

  // Default parameter values.
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int ACC_BITS_DEF    = 32;

  // Fixed field widths.
  localparam int OMEGA_W = 28;
  localparam int QGAIN_W = 16;
  localparam int LGAIN_W = 24;
  localparam int STEP_W  = 32;
  localparam int OFF_W   = 32;
  localparam int TW_W    = 36;
  localparam int Q_W     = 36;

  // Serial multiplier defaults and bit counter width (covers ACC_BITS up to 63).
  localparam int MUL_A_W_DEF = 36;
  localparam int MUL_B_W_DEF = 36;
  localparam int CNT_W       = 6;

  // Configuration port.
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  // Register reset values.
  localparam logic [OMEGA_W-1:0] CENTER_RST = 28'd20588742;
  localparam logic [QGAIN_W-1:0] QGAIN_RST  = 16'd5793;
  localparam logic [LGAIN_W-1:0] LGAIN_RST  = 24'd12800;
  localparam logic [STEP_W-1:0]  STEP_RST   = 32'd429497;

  typedef enum logic [1:0] {
    REG_CENTER = 2'd0,
    REG_QGAIN  = 2'd1,
    REG_LGAIN  = 2'd2,
    REG_STEP   = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [OMEGA_W-1:0] center_omega;
    logic [QGAIN_W-1:0] quad_gain;
    logic [LGAIN_W-1:0] loop_gain;
    logic [STEP_W-1:0]  step_time;
  } cfg_t;

  typedef struct packed {
    logic             start;
    logic             b_signed;
    logic [CNT_W-1:0] nbits;
  } mul_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_E1,
    ST_ISSUE,
    ST_WAIT,
    ST_OMEGA,
    ST_OUT
  } state_t;

  // Products in the order the sequencer runs them.
  typedef enum logic [2:0] {
    OP_KE1,
    OP_TW,
    OP_TWE2,
    OP_TWA,
    OP_P,
    OP_Q,
    OP_DW
  } op_t;

endpackage

`default_nettype wire

// ===== src/sogi_fll_quadrature_generator.sv =====
// Top level of the SOGI-FLL quadrature generator: configuration registers and core.
//
// Each input word carries one grid sample (signed Q1.15 at the default width)
// and a restart flag that reloads the initial state before the sample is used.
// Each input word yields exactly one result word: the in-phase signal alpha,
// the quadrature signal beta (both signed, saturated) and the frequency
// estimate omega (unsigned Q12.16 rad/s, clamped).
// Both channels use valid/stall; a word moves at a clock edge with valid high
// and stall low. in_stall is high from acceptance until the result is placed
// in the output register, so one sample is in flight at a time.
// All seven products run on one shift-add multiplier at one multiplier bit per
// cycle, which sets the rate; the next word can be taken once the core is back
// in idle after its result is loaded.
// A finished result waits in the output register while the receiver stalls;
// the core then holds until that register is free, and a new sample can still
// be accepted while the previous result waits.
// Reset (rst_n low at a clock edge) loads register defaults, clears the integrators
// and the frequency offset, and sets the frequency to the center. Registers are
// to be written over the APB port only while idle; the block does not enforce it.
`default_nettype none

module sogi_fll_quadrature_generator #(
  parameter int SAMPLE_BITS = sogifll_pkg::SAMPLE_BITS_DEF,
  parameter int ACC_BITS    = sogifll_pkg::ACC_BITS_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 psel,
  input  wire logic                                 penable,
  input  wire logic                                 pwrite,
  input  wire logic [sogifll_pkg::PADDR_W-1:0]      paddr,
  input  wire logic [sogifll_pkg::PDATA_W-1:0]      pwdata,
  output logic      [sogifll_pkg::PDATA_W-1:0]      prdata,
  output logic                                      pready,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic signed [SAMPLE_BITS-1:0]        in_sample,
  input  wire logic                                 in_restart,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic signed [SAMPLE_BITS-1:0]             out_alpha_out,
  output logic signed [SAMPLE_BITS-1:0]             out_beta_out,
  output logic        [sogifll_pkg::OMEGA_W-1:0]    out_omega_out
);

  sogifll_pkg::cfg_t cfg;

  sogifll_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  sogifll_core #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .ACC_BITS    (ACC_BITS)
  ) u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_sample     (in_sample),
    .in_restart    (in_restart),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_alpha_out (out_alpha_out),
    .out_beta_out  (out_beta_out),
    .out_omega_out (out_omega_out)
  );

endmodule

`default_nettype wire

// ===== src/sogifll_cfg.sv =====
// APB-style configuration registers of the SOGI-FLL quadrature generator.
`default_nettype none

module sogifll_cfg (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [sogifll_pkg::PADDR_W-1:0]    paddr,
  input  wire logic [sogifll_pkg::PDATA_W-1:0]    pwdata,
  output logic      [sogifll_pkg::PDATA_W-1:0]    prdata,
  output logic                                    pready,
  output sogifll_pkg::cfg_t                       cfg
);

  sogifll_pkg::cfg_t      cfg_r;
  sogifll_pkg::reg_idx_t  idx;
  logic                   wr_en;

  assign idx   = sogifll_pkg::reg_idx_t'(paddr[3:2]);
  assign wr_en = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg   = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.center_omega <= sogifll_pkg::CENTER_RST;
      cfg_r.quad_gain    <= sogifll_pkg::QGAIN_RST;
      cfg_r.loop_gain    <= sogifll_pkg::LGAIN_RST;
      cfg_r.step_time    <= sogifll_pkg::STEP_RST;
    end else if (wr_en) begin
      case (idx)
        sogifll_pkg::REG_CENTER: begin
          cfg_r.center_omega <= pwdata[sogifll_pkg::OMEGA_W-1:0];
        end
        sogifll_pkg::REG_QGAIN: begin
          cfg_r.quad_gain <= pwdata[sogifll_pkg::QGAIN_W-1:0];
        end
        sogifll_pkg::REG_LGAIN: begin
          cfg_r.loop_gain <= pwdata[sogifll_pkg::LGAIN_W-1:0];
        end
        sogifll_pkg::REG_STEP: begin
          cfg_r.step_time <= pwdata[sogifll_pkg::STEP_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (idx)
      sogifll_pkg::REG_CENTER: prdata = sogifll_pkg::PDATA_W'(cfg_r.center_omega);
      sogifll_pkg::REG_QGAIN:  prdata = sogifll_pkg::PDATA_W'(cfg_r.quad_gain);
      sogifll_pkg::REG_LGAIN:  prdata = sogifll_pkg::PDATA_W'(cfg_r.loop_gain);
      sogifll_pkg::REG_STEP:   prdata = sogifll_pkg::PDATA_W'(cfg_r.step_time);
      default:                 prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== src/sogifll_mul.sv =====
// Serial-parallel multiplier: one multiplier bit per cycle, full product kept.
`default_nettype none

module sogifll_mul #(
  parameter int A_W = sogifll_pkg::MUL_A_W_DEF,
  parameter int B_W = sogifll_pkg::MUL_B_W_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire sogifll_pkg::mul_ctl_t    ctl,
  input  wire logic signed [A_W-1:0]    a,
  input  wire logic        [B_W-1:0]    b,
  output logic                          done,
  output logic             [A_W+B_W:0]  prod
);

  logic                              run_r;
  logic                              done_r;
  logic [sogifll_pkg::CNT_W-1:0]     cnt_r;
  logic                              bsgn_r;
  logic signed [A_W-1:0]             a_r;
  logic signed [A_W:0]               acc_r;
  logic [B_W-1:0]                    bsh_r;

  logic                              last;
  logic signed [A_W+1:0]             a_ext;
  logic signed [A_W+1:0]             addend;
  logic signed [A_W+1:0]             sum;

  assign last  = (cnt_r == sogifll_pkg::CNT_W'(1));
  assign a_ext = (A_W+2)'(a_r);

  // A signed multiplier weighs its top bit negatively, so the last step subtracts.
  always_comb begin
    if (!bsh_r[0]) begin
      addend = '0;
    end else if (last && bsgn_r) begin
      addend = -a_ext;
    end else begin
      addend = a_ext;
    end
    sum = (A_W+2)'(acc_r) + addend;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= run_r && last && !ctl.start;
      if (ctl.start) begin
        run_r <= 1'b1;
      end else if (run_r && last) begin
        run_r <= 1'b0;
      end
    end
  end

  // The low product bits shift in from the top as the multiplier bits shift out.
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      a_r    <= a;
      acc_r  <= '0;
      bsh_r  <= b;
      cnt_r  <= ctl.nbits;
      bsgn_r <= ctl.b_signed;
    end else if (run_r) begin
      acc_r <= sum[A_W+1:1];
      bsh_r <= {sum[0], bsh_r[B_W-1:1]};
      cnt_r <= cnt_r - sogifll_pkg::CNT_W'(1);
    end
  end

  assign done = done_r;
  assign prod = {acc_r, bsh_r};

endmodule

`default_nettype wire

// ===== src/sogifll_core.sv =====
// Sequencer and fixed-point datapath of the SOGI-FLL, built around one serial multiplier.
`default_nettype none

module sogifll_core #(
  parameter int SAMPLE_BITS = sogifll_pkg::SAMPLE_BITS_DEF,
  parameter int ACC_BITS    = sogifll_pkg::ACC_BITS_DEF
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire sogifll_pkg::cfg_t                      cfg,
  input  wire logic                                   in_valid,
  output logic                                        in_stall,
  input  wire logic signed [SAMPLE_BITS-1:0]          in_sample,
  input  wire logic                                   in_restart,
  output logic                                        out_valid,
  input  wire logic                                   out_stall,
  output logic signed [SAMPLE_BITS-1:0]               out_alpha_out,
  output logic signed [SAMPLE_BITS-1:0]               out_beta_out,
  output logic        [sogifll_pkg::OMEGA_W-1:0]      out_omega_out
);

  localparam int SB   = SAMPLE_BITS;
  localparam int AW   = ACC_BITS;
  localparam int FB   = AW - 2;
  localparam int XSH  = FB - (SB - 1);
  localparam int LSH  = (XSH > 0) ? XSH : 0;
  localparam int RSH  = (XSH < 0) ? -XSH : 0;
  localparam int WA   = (AW + 2 > sogifll_pkg::TW_W) ? AW + 2 : sogifll_pkg::TW_W;
  localparam int WB   = (AW > sogifll_pkg::TW_W) ? AW : sogifll_pkg::TW_W;
  localparam int PW   = WA + WB + 1;
  localparam int SHW  = $clog2(PW);
  localparam int SW   = AW + 14;
  localparam int OW   = AW + SB + 2;
  localparam int OMW  = sogifll_pkg::OMEGA_W;
  localparam int OFW  = sogifll_pkg::OFF_W;
  localparam int CW   = sogifll_pkg::CNT_W;

  sogifll_pkg::state_t state_r, state_nxt;
  sogifll_pkg::op_t    op_r, op_nxt;

  logic                     out_valid_r;
  logic signed [SB-1:0]     out_alpha_r;
  logic signed [SB-1:0]     out_beta_r;
  logic [OMW-1:0]           out_omega_r;

  logic signed [SB-1:0]     sample_r;
  logic signed [AW-1:0]     alpha_r;
  logic signed [AW-1:0]     beta_r;
  logic signed [OFW-1:0]    off_r;
  logic [OMW-1:0]           omega_r;
  logic signed [AW-1:0]     e1_r;
  logic signed [AW-1:0]     e2_r;
  logic [sogifll_pkg::TW_W-1:0] tw_r;
  logic signed [AW+1:0]     p_r;
  logic signed [sogifll_pkg::Q_W-1:0] q_r;

  sogifll_pkg::mul_ctl_t    mul_ctl;
  logic                     mul_start;
  logic signed [WA-1:0]     mul_a;
  logic [WB-1:0]            mul_b;
  logic                     mul_done;
  logic [PW-1:0]            mul_prod;
  logic [SHW-1:0]           mul_shamt;

  logic                     in_take;
  logic                     out_free;
  logic                     e1_en;
  logic                     res_en;
  logic                     omega_en;
  logic                     out_load;

  logic signed [AW+SB-1:0]  xl;
  logic signed [AW-1:0]     x;
  logic signed [AW:0]       d1;
  logic signed [AW-1:0]     e1_sat;
  logic signed [PW-1:0]     prod_sh;
  logic signed [SW-1:0]     mres;
  logic signed [SW:0]       sum_w;
  logic signed [AW-1:0]     sum_acc;
  logic signed [OFW-1:0]    sum_off;
  logic signed [OMW+5:0]    wsum;
  logic [OMW-1:0]           w;

  // Floor from Q2.(ACC_BITS-2) to the sample format, then saturate.
  function automatic logic signed [SAMPLE_BITS-1:0] to_out(input logic signed [AW-1:0] v);
    logic signed [OW-1:0] t;
    logic                 fits;
    t = OW'(v);
    t = (t <<< RSH) >>> LSH;
    fits = (&t[OW-1:SB-1]) || !(|t[OW-1:SB-1]);
    if (fits) begin
      return t[SB-1:0];
    end else begin
      return {t[OW-1], {(SB-1){~t[OW-1]}}};
    end
  endfunction

  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // Next state and operation.
  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    case (state_r)
      sogifll_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = sogifll_pkg::ST_E1;
      end
      sogifll_pkg::ST_E1: begin
        state_nxt = sogifll_pkg::ST_ISSUE;
        op_nxt    = sogifll_pkg::OP_KE1;
      end
      sogifll_pkg::ST_ISSUE: begin
        state_nxt = sogifll_pkg::ST_WAIT;
      end
      sogifll_pkg::ST_WAIT: begin
        if (mul_done) begin
          state_nxt = sogifll_pkg::ST_ISSUE;
          case (op_r)
            sogifll_pkg::OP_KE1:  op_nxt = sogifll_pkg::OP_TW;
            sogifll_pkg::OP_TW:   op_nxt = sogifll_pkg::OP_TWE2;
            sogifll_pkg::OP_TWE2: op_nxt = sogifll_pkg::OP_TWA;
            sogifll_pkg::OP_TWA:  op_nxt = sogifll_pkg::OP_P;
            sogifll_pkg::OP_P:    op_nxt = sogifll_pkg::OP_Q;
            sogifll_pkg::OP_Q:    op_nxt = sogifll_pkg::OP_DW;
            sogifll_pkg::OP_DW:   state_nxt = sogifll_pkg::ST_OMEGA;
            default:              state_nxt = sogifll_pkg::ST_IDLE;
          endcase
        end
      end
      sogifll_pkg::ST_OMEGA: begin
        state_nxt = sogifll_pkg::ST_OUT;
      end
      sogifll_pkg::ST_OUT: begin
        if (out_free) state_nxt = sogifll_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = sogifll_pkg::ST_IDLE;
      end
    endcase
  end

  // Decoded controls of the sequencer.
  always_comb begin
    in_stall  = 1'b1;
    e1_en     = 1'b0;
    res_en    = 1'b0;
    omega_en  = 1'b0;
    out_load  = 1'b0;
    mul_start = 1'b0;
    case (state_r)
      sogifll_pkg::ST_IDLE:  in_stall = 1'b0;
      sogifll_pkg::ST_E1:    e1_en = 1'b1;
      sogifll_pkg::ST_ISSUE: mul_start = 1'b1;
      sogifll_pkg::ST_WAIT:  res_en = mul_done;
      sogifll_pkg::ST_OMEGA: omega_en = 1'b1;
      sogifll_pkg::ST_OUT:   out_load = out_free;
      default: begin
      end
    endcase
  end

  // Operand routing and final scaling of each product.
  always_comb begin
    mul_ctl.start    = mul_start;
    mul_ctl.b_signed = 1'b0;
    case (op_r)
      sogifll_pkg::OP_KE1: begin
        mul_a = WA'(e1_r);
        mul_b = WB'(cfg.quad_gain);
        mul_ctl.nbits = CW'(sogifll_pkg::QGAIN_W);
        mul_shamt = SHW'(12 + WB - sogifll_pkg::QGAIN_W);
      end
      sogifll_pkg::OP_TW: begin
        mul_a = WA'(cfg.step_time);
        mul_b = WB'(omega_r);
        mul_ctl.nbits = CW'(OMW);
        mul_shamt = SHW'(24 + WB - OMW);
      end
      sogifll_pkg::OP_TWE2: begin
        mul_a = WA'(e2_r);
        mul_b = WB'(tw_r);
        mul_ctl.nbits = CW'(sogifll_pkg::TW_W);
        mul_shamt = SHW'(24 + WB - sogifll_pkg::TW_W);
      end
      sogifll_pkg::OP_TWA: begin
        mul_a = WA'(alpha_r);
        mul_b = WB'(tw_r);
        mul_ctl.nbits = CW'(sogifll_pkg::TW_W);
        mul_shamt = SHW'(24 + WB - sogifll_pkg::TW_W);
      end
      sogifll_pkg::OP_P: begin
        mul_a = WA'(e1_r);
        mul_b = WB'($unsigned(beta_r));
        mul_ctl.nbits = CW'(AW);
        mul_ctl.b_signed = 1'b1;
        mul_shamt = SHW'(FB + WB - AW);
      end
      sogifll_pkg::OP_Q: begin
        mul_a = WA'(p_r);
        mul_b = WB'(cfg.loop_gain);
        mul_ctl.nbits = CW'(sogifll_pkg::LGAIN_W);
        mul_shamt = SHW'(FB - 8 + WB - sogifll_pkg::LGAIN_W);
      end
      sogifll_pkg::OP_DW: begin
        mul_a = WA'(q_r);
        mul_b = WB'(cfg.step_time);
        mul_ctl.nbits = CW'(sogifll_pkg::STEP_W);
        mul_shamt = SHW'(32 + WB - sogifll_pkg::STEP_W);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
        mul_ctl.nbits = CW'(1);
        mul_shamt = '0;
      end
    endcase
  end

  sogifll_mul #(
    .A_W (WA),
    .B_W (WB)
  ) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mul_ctl),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  // Sample moved to the accumulator format, and the first error term.
  always_comb begin
    xl = (AW+SB)'(sample_r);
    xl = (xl <<< LSH) >>> RSH;
    x  = xl[AW-1:0];
    d1 = (AW+1)'(x) - (AW+1)'(alpha_r);
    if (d1[AW] == d1[AW-1]) begin
      e1_sat = d1[AW-1:0];
    end else begin
      e1_sat = {d1[AW], {(AW-1){~d1[AW]}}};
    end
  end

  // One saturating adder serves every integrator update.
  always_comb begin
    prod_sh = $signed(mul_prod) >>> mul_shamt;
    mres    = prod_sh[SW-1:0];
    case (op_r)
      sogifll_pkg::OP_KE1:  sum_w = (SW+1)'(mres) - (SW+1)'(beta_r);
      sogifll_pkg::OP_TWE2: sum_w = (SW+1)'(mres) + (SW+1)'(alpha_r);
      sogifll_pkg::OP_TWA:  sum_w = (SW+1)'(mres) + (SW+1)'(beta_r);
      sogifll_pkg::OP_DW:   sum_w = (SW+1)'(off_r) - (SW+1)'(mres);
      default:              sum_w = (SW+1)'(mres);
    endcase
    if ((&sum_w[SW:AW-1]) || !(|sum_w[SW:AW-1])) begin
      sum_acc = sum_w[AW-1:0];
    end else begin
      sum_acc = {sum_w[SW], {(AW-1){~sum_w[SW]}}};
    end
    if ((&sum_w[SW:OFW-1]) || !(|sum_w[SW:OFW-1])) begin
      sum_off = sum_w[OFW-1:0];
    end else begin
      sum_off = {sum_w[SW], {(OFW-1){~sum_w[SW]}}};
    end
  end

  // Frequency estimate, clamped to the unsigned output range.
  always_comb begin
    wsum = (OMW+6)'(cfg.center_omega) + (OMW+6)'(off_r);
    if (wsum[OMW+5]) begin
      w = '0;
    end else if (|wsum[OMW+4:OMW]) begin
      w = '1;
    end else begin
      w = wsum[OMW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sogifll_pkg::ST_IDLE;
      op_r        <= sogifll_pkg::OP_KE1;
      out_valid_r <= 1'b0;
      alpha_r     <= '0;
      beta_r      <= '0;
      off_r       <= '0;
      omega_r     <= sogifll_pkg::CENTER_RST;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (in_take && in_restart) begin
        alpha_r <= '0;
        beta_r  <= '0;
        off_r   <= '0;
        omega_r <= cfg.center_omega;
      end
      if (res_en) begin
        case (op_r)
          sogifll_pkg::OP_TWE2: alpha_r <= sum_acc;
          sogifll_pkg::OP_TWA:  beta_r  <= sum_acc;
          sogifll_pkg::OP_DW:   off_r   <= sum_off;
          default: begin
          end
        endcase
      end
      if (omega_en) begin
        omega_r <= w;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      sample_r <= in_sample;
    end
    if (e1_en) begin
      e1_r <= e1_sat;
    end
    if (res_en) begin
      case (op_r)
        sogifll_pkg::OP_KE1: e2_r <= sum_acc;
        sogifll_pkg::OP_TW:  tw_r <= prod_sh[sogifll_pkg::TW_W-1:0];
        sogifll_pkg::OP_P:   p_r  <= prod_sh[AW+1:0];
        sogifll_pkg::OP_Q:   q_r  <= prod_sh[sogifll_pkg::Q_W-1:0];
        default: begin
        end
      endcase
    end
    if (out_load) begin
      out_alpha_r <= to_out(alpha_r);
      out_beta_r  <= to_out(beta_r);
      out_omega_r <= omega_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_alpha_out = out_alpha_r;
  assign out_beta_out  = out_beta_r;
  assign out_omega_out = out_omega_r;

endmodule

`default_nettype wire
